FILE: rtl/sdcp_pkg.sv
// shared types and constants for the serial drive command parser
// no dependencies; used by sdcp_line_parser and serial_drive_command_parser
`timescale 1ns / 1ps

package sdcp_pkg;

    localparam int VALUE_BITS_DEFAULT = 16;
    localparam int TIME_BITS_DEFAULT  = 32;

    localparam int OUT_BITS   = 16;
    localparam int BYTE_BITS  = 8;
    localparam int CFG_BITS   = 32;
    localparam int ADDR_BITS  = 4;
    localparam int SERVO_BITS = 8;

    localparam logic [CFG_BITS-1:0]   SEND_INTERVAL_RESET     = 32'd100;
    localparam logic [CFG_BITS-1:0]   HEARTBEAT_TIMEOUT_RESET = 32'd1000;
    localparam logic [SERVO_BITS-1:0] SAFE_SERVO_RESET        = 8'd9;

    // characters the parser reacts to
    localparam logic [BYTE_BITS-1:0] CH_NEWLINE    = 8'h0a;
    localparam logic [BYTE_BITS-1:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [BYTE_BITS-1:0] CH_SPACE      = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_TAB        = 8'h09;
    localparam logic [BYTE_BITS-1:0] CH_VTAB       = 8'h0b;
    localparam logic [BYTE_BITS-1:0] CH_FORMFEED   = 8'h0c;
    localparam logic [BYTE_BITS-1:0] CH_RETURN     = 8'h0d;
    localparam logic [BYTE_BITS-1:0] CH_PLUS       = 8'h2b;
    localparam logic [BYTE_BITS-1:0] CH_MINUS      = 8'h2d;
    localparam logic [BYTE_BITS-1:0] CH_ZERO       = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_NINE       = 8'h39;

    typedef enum logic [1:0] {
        REG_SEND_INTERVAL     = 2'd0,
        REG_HEARTBEAT_TIMEOUT = 2'd1,
        REG_SAFE_SERVO        = 2'd2,
        REG_UNUSED            = 2'd3
    } reg_index_t;

    // command handed from the line parser to the top level
    typedef struct packed {
        logic                valid;
        logic [OUT_BITS-1:0] speed;
        logic [OUT_BITS-1:0] servo;
    } drive_cmd_t;

    // one result transaction
    typedef struct packed {
        logic                 drive_valid;
        logic                 from_timeout;
        logic [OUT_BITS-1:0]  speed;
        logic [OUT_BITS-1:0]  servo_code;
        logic                 report_valid;
        logic [OUT_BITS-1:0]  report_rpm;
        logic [BYTE_BITS-1:0] report_obstacle;
    } out_item_t;

endpackage

FILE: rtl/sdcp_line_parser.sv
// line parser: turns received bytes into speed/servo commands (atol style fields)
// depends on sdcp_pkg
`timescale 1ns / 1ps

module sdcp_line_parser #(
    parameter int VALUE_BITS = sdcp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_en,
    input  logic [sdcp_pkg::BYTE_BITS-1:0]  rx_byte,
    output sdcp_pkg::drive_cmd_t            cmd
);

    localparam int EXT_BITS = (VALUE_BITS > sdcp_pkg::OUT_BITS) ? VALUE_BITS
                                                                 : sdcp_pkg::OUT_BITS;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  second_reg, second_next;
    logic                  negative_reg, negative_next;
    logic [VALUE_BITS-1:0] first_reg, first_next;
    logic [VALUE_BITS-1:0] second_val_reg, second_val_next;

    logic                  is_digit, is_space, is_sign;
    logic [VALUE_BITS-1:0] acc, acc_next;
    logic [VALUE_BITS-1:0] first_signed, second_signed;

    assign is_digit = (rx_byte >= sdcp_pkg::CH_ZERO) && (rx_byte <= sdcp_pkg::CH_NINE);
    assign is_space = (rx_byte == sdcp_pkg::CH_SPACE) || (rx_byte == sdcp_pkg::CH_TAB)
                   || (rx_byte == sdcp_pkg::CH_VTAB) || (rx_byte == sdcp_pkg::CH_FORMFEED)
                   || (rx_byte == sdcp_pkg::CH_RETURN);
    assign is_sign  = (rx_byte == sdcp_pkg::CH_PLUS) || (rx_byte == sdcp_pkg::CH_MINUS);

    assign acc      = second_reg ? second_val_reg : first_reg;
    // acc * 10 + digit, wrapping at the field width
    assign acc_next = (acc << 3) + (acc << 1) + VALUE_BITS'(rx_byte[3:0]);

    assign first_signed  = negative_reg ? (VALUE_BITS'(0) - first_reg) : first_reg;
    assign second_signed = negative_reg ? (VALUE_BITS'(0) - second_val_reg) : second_val_reg;

    // value fields are zero-extended or truncated to the port width
    logic [EXT_BITS-1:0] speed_ext, servo_ext;
    assign speed_ext = EXT_BITS'(first_reg);
    assign servo_ext = EXT_BITS'(second_signed);

    // drive the command payload from the extended values
    logic [sdcp_pkg::OUT_BITS-1:0] speed_out, servo_out;
    assign speed_out = speed_ext[sdcp_pkg::OUT_BITS-1:0];
    assign servo_out = servo_ext[sdcp_pkg::OUT_BITS-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        second_next     = second_reg;
        negative_next   = negative_reg;
        first_next      = first_reg;
        second_val_next = second_val_reg;
        cmd.valid       = 1'b0;
        cmd.speed       = speed_out;
        cmd.servo       = servo_out;

        if (byte_en) begin
            if (rx_byte == sdcp_pkg::CH_NEWLINE) begin
                cmd.valid       = second_reg;
                phase_next      = PH_SKIP;
                second_next     = 1'b0;
                negative_next   = 1'b0;
                first_next      = '0;
                second_val_next = '0;
            end else if (rx_byte == sdcp_pkg::CH_UNDERSCORE && !second_reg) begin
                // first field is final: fold its sign in now
                first_next    = first_signed;
                second_next   = 1'b1;
                phase_next    = PH_SKIP;
                negative_next = 1'b0;
            end else begin
                case (phase_reg)
                    PH_SKIP:
                    begin
                        if (is_sign) begin
                            negative_next = (rx_byte == sdcp_pkg::CH_MINUS);
                            phase_next    = PH_DIGITS;
                        end else if (is_digit) begin
                            phase_next = PH_DIGITS;
                            if (second_reg)
                                second_val_next = acc_next;
                            else
                                first_next = acc_next;
                        end else if (!is_space) begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit) begin
                            if (second_reg)
                                second_val_next = acc_next;
                            else
                                first_next = acc_next;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_SKIP;
            second_reg     <= 1'b0;
            negative_reg   <= 1'b0;
            first_reg      <= '0;
            second_val_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            second_reg     <= second_next;
            negative_reg   <= negative_next;
            first_reg      <= first_next;
            second_val_reg <= second_val_next;
        end
    end

endmodule

FILE: rtl/serial_drive_command_parser.sv
// top level: apb registers, millisecond timers, parser and output queue
// depends on sdcp_pkg and sdcp_line_parser
//
//  channel   signals                                         direction
//  input     in_valid, in_stall, mode, rx_byte, rpm_value,   into block
//            obstacle_state
//  output    out_valid, out_stall, drive_valid ... report_*  out of block
//  config    psel, penable, pwrite, paddr, pwdata, prdata    apb slave
//
//  one input transaction per cycle while in_stall is low; a result is registered on acceptance
//  the parser and timers update in the accept cycle, the result sits in an
//  output register backed by one skid entry
//  in_stall rises only while the skid entry is occupied by a stalled result
//  reset clears all control state and restores the register reset values; the result data registers are not reset
`timescale 1ns / 1ps

module serial_drive_command_parser #(
    parameter int VALUE_BITS = sdcp_pkg::VALUE_BITS_DEFAULT,
    parameter int TIME_BITS  = sdcp_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sdcp_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [sdcp_pkg::CFG_BITS-1:0]    pwdata,
    output logic [sdcp_pkg::CFG_BITS-1:0]    prdata,
    output logic                             pready,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [sdcp_pkg::BYTE_BITS-1:0]   rx_byte,
    input  logic signed [sdcp_pkg::OUT_BITS-1:0] rpm_value,
    input  logic [sdcp_pkg::BYTE_BITS-1:0]   obstacle_state,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             drive_valid,
    output logic                             from_timeout,
    output logic signed [sdcp_pkg::OUT_BITS-1:0] speed,
    output logic signed [sdcp_pkg::OUT_BITS-1:0] servo_code,
    output logic                             report_valid,
    output logic signed [sdcp_pkg::OUT_BITS-1:0] report_rpm,
    output logic [sdcp_pkg::BYTE_BITS-1:0]   report_obstacle
);

    localparam int CMP_BITS = (TIME_BITS > sdcp_pkg::CFG_BITS) ? TIME_BITS
                                                                : sdcp_pkg::CFG_BITS;

    // ---------------- configuration registers ----------------
    logic [sdcp_pkg::CFG_BITS-1:0]   send_interval_reg;
    logic [sdcp_pkg::CFG_BITS-1:0]   heartbeat_timeout_reg;
    logic [sdcp_pkg::SERVO_BITS-1:0] safe_servo_reg;
    logic                            cfg_write;
    sdcp_pkg::reg_index_t            cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = sdcp_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            send_interval_reg     <= sdcp_pkg::SEND_INTERVAL_RESET;
            heartbeat_timeout_reg <= sdcp_pkg::HEARTBEAT_TIMEOUT_RESET;
            safe_servo_reg        <= sdcp_pkg::SAFE_SERVO_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                sdcp_pkg::REG_SEND_INTERVAL:     send_interval_reg     <= pwdata;
                sdcp_pkg::REG_HEARTBEAT_TIMEOUT: heartbeat_timeout_reg <= pwdata;
                sdcp_pkg::REG_SAFE_SERVO:
                    safe_servo_reg <= pwdata[sdcp_pkg::SERVO_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            sdcp_pkg::REG_SEND_INTERVAL:     prdata = send_interval_reg;
            sdcp_pkg::REG_HEARTBEAT_TIMEOUT: prdata = heartbeat_timeout_reg;
            sdcp_pkg::REG_SAFE_SERVO:
                prdata = sdcp_pkg::CFG_BITS'(safe_servo_reg);
            default:                         prdata = '0;
        endcase
    end

    // ---------------- input transaction ----------------
    logic in_accept, byte_en, tick_en;

    assign in_accept = in_valid && !in_stall;
    assign byte_en   = in_accept && !mode;
    assign tick_en   = in_accept && mode;

    sdcp_pkg::drive_cmd_t cmd;

    sdcp_line_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_line_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (rx_byte),
        .cmd     (cmd)
    );

    // ---------------- millisecond timers ----------------
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] last_heartbeat_reg, last_heartbeat_next;
    logic [TIME_BITS-1:0] last_report_reg, last_report_next;
    logic [TIME_BITS-1:0] report_age, heartbeat_age;
    logic                 report_due, timed_out;

    assign now_next      = tick_en ? (now_reg + TIME_BITS'(1)) : now_reg;
    assign report_age    = now_next - last_report_reg;
    assign heartbeat_age = now_next - last_heartbeat_reg;
    assign report_due    = tick_en
                        && (CMP_BITS'(report_age) >= CMP_BITS'(send_interval_reg));
    assign timed_out     = tick_en
                        && (CMP_BITS'(heartbeat_age) > CMP_BITS'(heartbeat_timeout_reg));

    assign last_report_next    = report_due ? now_next : last_report_reg;
    assign last_heartbeat_next = cmd.valid ? now_reg : last_heartbeat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            now_reg            <= '0;
            last_heartbeat_reg <= '0;
            last_report_reg    <= '0;
        end else begin
            now_reg            <= now_next;
            last_heartbeat_reg <= last_heartbeat_next;
            last_report_reg    <= last_report_next;
        end
    end

    // ---------------- result assembly ----------------
    sdcp_pkg::out_item_t new_item;
    logic                push;

    always_comb
    begin
        new_item = '0;
        if (cmd.valid) begin
            new_item.drive_valid = 1'b1;
            new_item.speed       = cmd.speed;
            new_item.servo_code  = cmd.servo;
        end
        if (report_due) begin
            new_item.report_valid    = 1'b1;
            new_item.report_rpm      = rpm_value;
            new_item.report_obstacle = obstacle_state;
        end
        if (timed_out) begin
            new_item.drive_valid  = 1'b1;
            new_item.from_timeout = 1'b1;
            new_item.speed        = '0;
            new_item.servo_code   = sdcp_pkg::OUT_BITS'(safe_servo_reg);
        end
    end

    assign push = cmd.valid || report_due || timed_out;

    // ---------------- output register with skid entry ----------------
    sdcp_pkg::out_item_t out_item_reg, out_item_next;
    sdcp_pkg::out_item_t skid_item_reg, skid_item_next;
    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic                pop;

    assign pop      = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    always_comb
    begin
        out_item_next   = out_item_reg;
        out_valid_next  = out_valid_reg;
        skid_item_next  = skid_item_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg) begin
            if (pop) begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_item_next  = new_item;
                out_valid_next = 1'b1;
            end else begin
                skid_item_next  = new_item;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign out_valid       = out_valid_reg;
    assign drive_valid     = out_item_reg.drive_valid;
    assign from_timeout    = out_item_reg.from_timeout;
    assign speed           = out_item_reg.speed;
    assign servo_code      = out_item_reg.servo_code;
    assign report_valid    = out_item_reg.report_valid;
    assign report_rpm      = out_item_reg.report_rpm;
    assign report_obstacle = out_item_reg.report_obstacle;

    // ---------------- assertions ----------------
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_result_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_valid || report_valid))
        else $error("result transaction carries neither command nor report");

    a_timeout_is_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && from_timeout) |-> (drive_valid && speed == '0))
        else $error("safe state result without zero speed drive command");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode) |=> (now_reg == $past(now_reg) + TIME_BITS'(1)))
        else $error("millisecond counter did not advance on tick");

    a_byte_holds_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !mode) |=> (now_reg == $past(now_reg)))
        else $error("millisecond counter moved on a received byte");

endmodule

FILE: verif/drive_report_checker.sv
// checker for the serial drive command parser: snoops the register port and both channels,
// predicts every result from its own copy of the parser and timers, and counts mismatches
// depends on sdcp_pkg
`timescale 1ns / 1ps

module drive_report_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [sdcp_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [sdcp_pkg::CFG_BITS-1:0]        pwdata,

    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 mode,
    input  logic [sdcp_pkg::BYTE_BITS-1:0]       rx_byte,
    input  logic signed [sdcp_pkg::OUT_BITS-1:0] rpm_value,
    input  logic [sdcp_pkg::BYTE_BITS-1:0]       obstacle_state,

    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 drive_valid,
    input  logic                                 from_timeout,
    input  logic signed [sdcp_pkg::OUT_BITS-1:0] speed,
    input  logic signed [sdcp_pkg::OUT_BITS-1:0] servo_code,
    input  logic                                 report_valid,
    input  logic signed [sdcp_pkg::OUT_BITS-1:0] report_rpm,
    input  logic [sdcp_pkg::BYTE_BITS-1:0]       report_obstacle,

    output int                                   outstanding,
    output int                                   mismatches
);

    localparam int TB = sdcp_pkg::TIME_BITS_DEFAULT;
    localparam int OB = sdcp_pkg::OUT_BITS;
    localparam int BB = sdcp_pkg::BYTE_BITS;

    typedef enum logic [1:0] {
        SCAN_BLANK,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_phase_t;

    logic [sdcp_pkg::CFG_BITS-1:0]   cfg_interval;
    logic [sdcp_pkg::CFG_BITS-1:0]   cfg_timeout;
    logic [sdcp_pkg::SERVO_BITS-1:0] cfg_safe;

    logic [TB-1:0] clock_ms;
    logic [TB-1:0] heartbeat_ms;
    logic [TB-1:0] report_ms;
    logic          after_underscore;
    scan_phase_t   phase;
    logic          negative;
    logic [OB-1:0] speed_acc;
    logic [OB-1:0] servo_acc;

    sdcp_pkg::out_item_t awaited_results[$];
    sdcp_pkg::out_item_t predicted;
    sdcp_pkg::out_item_t wanted;
    sdcp_pkg::out_item_t observed;
    bit                  has_result;

    task automatic clear_line();
        after_underscore = 1'b0;
        phase            = SCAN_BLANK;
        negative         = 1'b0;
        speed_acc        = '0;
        servo_acc        = '0;
    endtask

    // one byte or one tick through the parser and the millisecond timers
    task automatic step_command_parser(input logic is_tick, input logic [BB-1:0] ch,
                                       input logic [OB-1:0] rpm,
                                       input logic [BB-1:0] obst,
                                       output bit emits, output sdcp_pkg::out_item_t res);
        logic [OB-1:0] acc;
        logic          is_digit;
        logic          is_blank;
        res   = '0;
        emits = 1'b0;
        if (!is_tick)
        begin
            if (ch == sdcp_pkg::CH_NEWLINE)
            begin
                if (after_underscore)
                begin
                    emits           = 1'b1;
                    res.drive_valid = 1'b1;
                    res.speed       = speed_acc;
                    res.servo_code  = negative ? -servo_acc : servo_acc;
                    heartbeat_ms    = clock_ms;
                end
                clear_line();
            end
            else if (ch == sdcp_pkg::CH_UNDERSCORE && !after_underscore)
            begin
                speed_acc        = negative ? -speed_acc : speed_acc;
                after_underscore = 1'b1;
                phase            = SCAN_BLANK;
                negative         = 1'b0;
            end
            else
            begin
                acc      = after_underscore ? servo_acc : speed_acc;
                is_digit = (ch >= sdcp_pkg::CH_ZERO) && (ch <= sdcp_pkg::CH_NINE);
                is_blank = ch inside {sdcp_pkg::CH_SPACE, sdcp_pkg::CH_TAB, sdcp_pkg::CH_VTAB,
                                      sdcp_pkg::CH_FORMFEED, sdcp_pkg::CH_RETURN};
                if (phase == SCAN_BLANK)
                begin
                    if (ch == sdcp_pkg::CH_PLUS || ch == sdcp_pkg::CH_MINUS)
                    begin
                        negative = (ch == sdcp_pkg::CH_MINUS);
                        phase    = SCAN_DIGITS;
                    end
                    else if (!is_blank)
                    begin
                        phase = is_digit ? SCAN_DIGITS : SCAN_DONE;
                    end
                end
                else if (phase == SCAN_DIGITS && !is_digit)
                begin
                    phase = SCAN_DONE;
                end
                // a sign leaves is_digit low, so only real digits accumulate
                if (phase == SCAN_DIGITS && is_digit)
                begin
                    acc = acc * OB'(10) + OB'(ch - sdcp_pkg::CH_ZERO);
                end
                if (after_underscore)
                begin
                    servo_acc = acc;
                end
                else
                begin
                    speed_acc = acc;
                end
            end
        end
        else
        begin
            clock_ms = clock_ms + TB'(1);
            if (clock_ms - report_ms >= cfg_interval)
            begin
                emits               = 1'b1;
                res.report_valid    = 1'b1;
                res.report_rpm      = rpm;
                res.report_obstacle = obst;
                report_ms           = clock_ms;
            end
            if (clock_ms - heartbeat_ms > cfg_timeout)
            begin
                emits            = 1'b1;
                res.drive_valid  = 1'b1;
                res.from_timeout = 1'b1;
                res.speed        = '0;
                res.servo_code   = OB'(cfg_safe);
            end
        end
    endtask

    task automatic check_field(input string label, input logic [OB-1:0] want,
                               input logic [OB-1:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
            begin
                $display("mismatch on %s: expected %0h, got %0h", label, want, got);
            end
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_interval = sdcp_pkg::SEND_INTERVAL_RESET;
            cfg_timeout  = sdcp_pkg::HEARTBEAT_TIMEOUT_RESET;
            cfg_safe     = sdcp_pkg::SAFE_SERVO_RESET;
            clock_ms     = '0;
            heartbeat_ms = '0;
            report_ms    = '0;
            clear_line();
            awaited_results.delete();
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (sdcp_pkg::reg_index_t'(paddr[sdcp_pkg::ADDR_BITS-1:2]))
                    sdcp_pkg::REG_SEND_INTERVAL:
                    begin
                        cfg_interval = pwdata;
                    end
                    sdcp_pkg::REG_HEARTBEAT_TIMEOUT:
                    begin
                        cfg_timeout = pwdata;
                    end
                    sdcp_pkg::REG_SAFE_SERVO:
                    begin
                        cfg_safe = pwdata[sdcp_pkg::SERVO_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            // results leave through the output register after their transaction, so compare before predicting
            if (out_valid && !out_stall)
            begin
                observed = '{drive_valid, from_timeout, speed, servo_code,
                             report_valid, report_rpm, report_obstacle};
                if (awaited_results.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected result: %p", observed);
                    end
                    mismatches++;
                end
                else
                begin
                    wanted = awaited_results.pop_front();
                    check_field("drive_valid", OB'(wanted.drive_valid),
                                OB'(observed.drive_valid));
                    check_field("from_timeout", OB'(wanted.from_timeout),
                                OB'(observed.from_timeout));
                    check_field("speed", wanted.speed, observed.speed);
                    check_field("servo_code", wanted.servo_code, observed.servo_code);
                    check_field("report_valid", OB'(wanted.report_valid),
                                OB'(observed.report_valid));
                    check_field("report_rpm", wanted.report_rpm, observed.report_rpm);
                    check_field("report_obstacle", OB'(wanted.report_obstacle),
                                OB'(observed.report_obstacle));
                end
            end

            if (in_valid && !in_stall)
            begin
                // mode high marks a millisecond tick
                step_command_parser(mode, rx_byte, rpm_value, obstacle_state,
                                    has_result, predicted);
                if (has_result)
                begin
                    awaited_results.push_back(predicted);
                end
            end

            outstanding <= awaited_results.size();
        end
    end

endmodule

FILE: verif/tb_serial_drive_command_parser.sv
// testbench top for serial_drive_command_parser: clock, reset, register writes, byte and
// tick stimulus with random idling and stalls; depends on sdcp_pkg and drive_report_checker
`timescale 1ns / 1ps

module tb_serial_drive_command_parser;

    localparam logic MODE_BYTE   = 1'b0;
    localparam logic MODE_TICK   = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   PHASE_ITEMS = 150;
    localparam int   OB          = sdcp_pkg::OUT_BITS;
    localparam int   BB          = sdcp_pkg::BYTE_BITS;

    logic                                 clk            = 1'b0;
    logic                                 rst_n          = 1'b0;
    logic                                 psel           = 1'b0;
    logic                                 penable        = 1'b0;
    logic                                 pwrite         = 1'b0;
    logic [sdcp_pkg::ADDR_BITS-1:0]       paddr          = '0;
    logic [sdcp_pkg::CFG_BITS-1:0]        pwdata         = '0;
    logic [sdcp_pkg::CFG_BITS-1:0]        prdata;
    logic                                 pready;
    logic                                 in_valid       = 1'b0;
    logic                                 in_stall;
    logic                                 mode           = MODE_BYTE;
    logic [BB-1:0]                        rx_byte        = '0;
    logic signed [OB-1:0]                 rpm_value      = '0;
    logic [BB-1:0]                        obstacle_state = '0;
    logic                                 out_valid;
    logic                                 out_stall      = 1'b0;
    logic                                 drive_valid;
    logic                                 from_timeout;
    logic signed [OB-1:0]                 speed;
    logic signed [OB-1:0]                 servo_code;
    logic                                 report_valid;
    logic signed [OB-1:0]                 report_rpm;
    logic [BB-1:0]                        report_obstacle;

    int outstanding;
    int mismatches;
    int cycle_count = 0;
    int items_sent  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    logic [BB-1:0] blanks [5] = '{sdcp_pkg::CH_SPACE, sdcp_pkg::CH_TAB, sdcp_pkg::CH_VTAB,
                                  sdcp_pkg::CH_FORMFEED, sdcp_pkg::CH_RETURN};

    serial_drive_command_parser uut (.*);

    drive_report_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("serial_drive_command_parser regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input sdcp_pkg::reg_index_t idx,
                             input logic [sdcp_pkg::CFG_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // holds the transaction until the edge that accepts it
    task automatic send_item(input logic is_tick, input logic [BB-1:0] ch,
                             input logic [OB-1:0] rpm, input logic [BB-1:0] obst);
        int gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= is_tick;
        rx_byte        <= ch;
        rpm_value      <= rpm;
        obstacle_state <= obst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [BB-1:0] ch);
        send_item(MODE_BYTE, ch, OB'($urandom), BB'($urandom));
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, BB'($urandom), OB'($urandom), BB'($urandom));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // leading blanks, optional sign, then digits; long runs overflow the value width
    task automatic send_number();
        int ndigits;
        repeat ($urandom_range(2)) send_byte(blanks[$urandom_range(4)]);
        case ($urandom_range(3))
            0:
            begin
                send_byte(sdcp_pkg::CH_MINUS);
            end
            1:
            begin
                send_byte(sdcp_pkg::CH_PLUS);
            end
            default:
            begin
            end
        endcase
        ndigits = ($urandom_range(9) == 0) ? $urandom_range(12, 6) : $urandom_range(5, 1);
        repeat (ndigits) send_byte(sdcp_pkg::CH_ZERO + BB'($urandom_range(9)));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_traffic(input int quota);
        int  start  = items_sent;
        bit  paused = 1'b0;
        while (items_sent - start < quota)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4:
                begin
                    send_number();
                    send_byte(sdcp_pkg::CH_UNDERSCORE);
                    send_number();
                    case ($urandom_range(5))
                        0:
                        begin
                            send_byte(sdcp_pkg::CH_UNDERSCORE);
                        end
                        1:
                        begin
                            send_byte(sdcp_pkg::CH_SPACE);
                        end
                        2:
                        begin
                            send_byte(sdcp_pkg::CH_PLUS);
                        end
                        default:
                        begin
                        end
                    endcase
                    send_byte(sdcp_pkg::CH_NEWLINE);
                end
                5, 6:
                begin
                    repeat ($urandom_range(6, 1)) send_tick();
                end
                7:
                begin
                    case ($urandom_range(3))
                        0:
                        begin
                            // no underscore: line is dropped
                            send_number();
                        end
                        1:
                        begin
                            send_number();
                            send_byte(sdcp_pkg::CH_UNDERSCORE);
                            send_number();
                            send_byte(sdcp_pkg::CH_UNDERSCORE);
                            send_number();
                        end
                        2:
                        begin
                            if ($urandom_range(1))
                            begin
                                send_byte(sdcp_pkg::CH_MINUS);
                            end
                            send_byte(sdcp_pkg::CH_UNDERSCORE);
                            if ($urandom_range(1))
                            begin
                                send_byte(sdcp_pkg::CH_PLUS);
                            end
                        end
                        default:
                        begin
                            repeat ($urandom_range(5, 1)) send_byte(BB'($urandom_range(255)));
                        end
                    endcase
                    send_byte(sdcp_pkg::CH_NEWLINE);
                end
                default:
                begin
                    repeat ($urandom_range(4, 1)) send_byte(BB'($urandom_range(255)));
                end
            endcase
            if (!paused && items_sent - start >= quota / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: blanks, sign, overflow, empty fields, dropped line
        send_byte(sdcp_pkg::CH_SPACE);
        send_byte(sdcp_pkg::CH_TAB);
        send_byte(sdcp_pkg::CH_VTAB);
        send_byte(sdcp_pkg::CH_FORMFEED);
        send_byte(sdcp_pkg::CH_RETURN);
        send_text("-7_99999");
        send_byte(sdcp_pkg::CH_NEWLINE);
        send_text("+_-");
        send_byte(sdcp_pkg::CH_NEWLINE);
        send_text("x");
        send_byte(sdcp_pkg::CH_NEWLINE);
        send_text("1_2_3");
        send_byte(sdcp_pkg::CH_NEWLINE);
        send_tick();

        // report and timeout due on every tick
        drain_results();
        write_reg(sdcp_pkg::REG_SEND_INTERVAL, '0);
        write_reg(sdcp_pkg::REG_HEARTBEAT_TIMEOUT, '0);
        write_reg(sdcp_pkg::REG_SAFE_SERVO, 32'h0000_00ff);
        send_item(MODE_TICK, '0, 16'h8000, 8'hff);
        send_text("32767_-32768");
        send_byte(sdcp_pkg::CH_NEWLINE);
        send_item(MODE_TICK, 8'hff, 16'h7fff, '0);

        for (int p = 0; p < 4; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    write_reg(sdcp_pkg::REG_SEND_INTERVAL, $urandom_range(3));
                    write_reg(sdcp_pkg::REG_HEARTBEAT_TIMEOUT, $urandom_range(6));
                    write_reg(sdcp_pkg::REG_SAFE_SERVO, $urandom);
                end
                1:
                begin
                    idle_pct = 49;
                    stall_pct <= 0;
                    write_reg(sdcp_pkg::REG_SEND_INTERVAL, $urandom_range(7, 1));
                    write_reg(sdcp_pkg::REG_HEARTBEAT_TIMEOUT, $urandom_range(25, 3));
                    write_reg(sdcp_pkg::REG_SAFE_SERVO, $urandom);
                end
                2:
                begin
                    // nothing on ticks at all; drive lines only
                    idle_pct = 0;
                    stall_pct <= 49;
                    write_reg(sdcp_pkg::REG_SEND_INTERVAL, 32'hffff_ffff);
                    write_reg(sdcp_pkg::REG_HEARTBEAT_TIMEOUT, 32'hffff_ffff);
                    write_reg(sdcp_pkg::REG_SAFE_SERVO, '0);
                end
                default:
                begin
                    idle_pct = 9;
                    stall_pct <= 9;
                    write_reg(sdcp_pkg::REG_SEND_INTERVAL, $urandom_range(10));
                    write_reg(sdcp_pkg::REG_HEARTBEAT_TIMEOUT, $urandom_range(40));
                    write_reg(sdcp_pkg::REG_SAFE_SERVO, $urandom);
                end
            endcase
            random_traffic(PHASE_ITEMS);
        end

        drain_results();
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("serial_drive_command_parser regression: pass");
        end
        else
        begin
            $display("serial_drive_command_parser regression: fail");
        end
        $finish;
    end

endmodule
